// ===== sv/sddc_pkg.sv =====
`default_nettype none
package sddc_pkg;

   localparam int ByteWidth  = 8;
   localparam int MagWidth   = 31;
   localparam int ValueWidth = MagWidth + 2;
   localparam int DirWidth   = 2;

   localparam logic [ByteWidth-1:0]  CharTab   = 8'd9;
   localparam logic [ByteWidth-1:0]  CharLf    = 8'd10;
   localparam logic [ByteWidth-1:0]  CharVt    = 8'd11;
   localparam logic [ByteWidth-1:0]  CharFf    = 8'd12;
   localparam logic [ByteWidth-1:0]  CharCr    = 8'd13;
   localparam logic [ByteWidth-1:0]  CharSpace = 8'd32;
   localparam logic [ByteWidth-1:0]  CharPlus  = 8'd43;
   localparam logic [ByteWidth-1:0]  CharMinus = 8'd45;
   localparam logic [ByteWidth-1:0]  CharZero  = 8'd48;
   localparam logic [ByteWidth-1:0]  CharNine  = 8'd57;
   localparam logic [ByteWidth-1:0]  LimitReset = 8'd255;
   localparam logic [MagWidth-1:0]   MagMax    = {MagWidth{1'b1}};

   typedef enum logic [1:0] {
      PH_SKIP   = 2'd0,
      PH_DIGITS = 2'd1,
      PH_STOP   = 2'd2
   } phase_type;

   typedef enum logic [DirWidth-1:0] {
      DIR_RELEASE  = 2'd0,
      DIR_FORWARD  = 2'd1,
      DIR_BACKWARD = 2'd2
   } dir_type;

   typedef struct packed {
      logic clear;
      logic step;
   } field_ctl_type;

   typedef struct packed {
      logic                negative;
      logic [MagWidth-1:0] magnitude;
   } number_type;

endpackage
`default_nettype wire

// ===== sv/sddc_field.sv =====
`default_nettype none
module sddc_field (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire sddc_pkg::field_ctl_type     ctl,
   input  wire logic [sddc_pkg::ByteWidth-1:0] rx_byte,
   output sddc_pkg::number_type             number
);
   import sddc_pkg::*;

   phase_type           phase_ff, phase_in;
   logic                neg_ff, neg_in;
   logic [MagWidth-1:0] mag_ff, mag_in;

   logic                digit;
   logic                space;
   logic [MagWidth-1:0] digit_val;
   logic [MagWidth+3:0] acc;

   assign digit = (rx_byte >= CharZero) && (rx_byte <= CharNine);
   assign space = (rx_byte == CharTab) || (rx_byte == CharVt) ||
                  (rx_byte == CharFf) || (rx_byte == CharSpace);
   assign digit_val = {{(MagWidth-4){1'b0}}, 4'(rx_byte - CharZero)};
   assign acc = ({4'b0, mag_ff} << 3) + ({4'b0, mag_ff} << 1) + {4'b0, digit_val};

   always_comb begin
      phase_in = phase_ff;
      neg_in   = neg_ff;
      mag_in   = mag_ff;
      if (ctl.clear) begin
         phase_in = PH_SKIP;
         neg_in   = 1'b0;
         mag_in   = '0;
      end else if (ctl.step) begin
         case (phase_ff)
            PH_SKIP: begin
               if (!space) begin
                  if (rx_byte == CharPlus || rx_byte == CharMinus) begin
                     neg_in   = (rx_byte == CharMinus);
                     phase_in = PH_DIGITS;
                  end else if (digit) begin
                     mag_in   = digit_val;
                     phase_in = PH_DIGITS;
                  end else begin
                     phase_in = PH_STOP;
                  end
               end
            end
            PH_DIGITS: begin
               if (digit) begin
                  mag_in = (acc > {4'b0, MagMax}) ? MagMax : acc[MagWidth-1:0];
               end else begin
                  phase_in = PH_STOP;
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SKIP;
         neg_ff   <= 1'b0;
         mag_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         neg_ff   <= neg_in;
         mag_ff   <= mag_in;
      end
   end

   assign number.negative  = neg_ff;
   assign number.magnitude = mag_ff;

endmodule
`default_nettype wire

// ===== sv/sddc_motor.sv =====
`default_nettype none
module sddc_motor (
   input  wire logic signed [sddc_pkg::ValueWidth-1:0] command,
   input  wire logic [sddc_pkg::ByteWidth-1:0]         limit,
   output sddc_pkg::dir_type                           direction,
   output logic [sddc_pkg::ByteWidth-1:0]              speed
);
   import sddc_pkg::*;

   logic signed [ValueWidth-1:0] lim_pos;
   logic signed [ValueWidth-1:0] lim_neg;
   logic signed [ValueWidth-1:0] clamped;
   logic signed [ValueWidth-1:0] negated;

   assign lim_pos = $signed({{(ValueWidth-ByteWidth){1'b0}}, limit});
   assign lim_neg = -lim_pos;

   always_comb begin
      if (command > lim_pos) begin
         clamped = lim_pos;
      end else if (command < lim_neg) begin
         clamped = lim_neg;
      end else begin
         clamped = command;
      end
      negated = -clamped;
      if (clamped > 0) begin
         direction = DIR_FORWARD;
         speed     = clamped[ByteWidth-1:0];
      end else if (clamped < 0) begin
         direction = DIR_BACKWARD;
         speed     = negated[ByteWidth-1:0];
      end else begin
         direction = DIR_RELEASE;
         speed     = '0;
      end
   end

endmodule
`default_nettype wire

// ===== sv/serial_differential_drive_command_unit.sv =====
`default_nettype none
// Input register parses; result register holds a good line's result once its end beat advances.
// Throughput: one byte beat per cycle while no line-end beat waits on a stalled result.
// A stalled result holds only a line-end byte; other bytes keep flowing.
// Reset (synchronous, active high) clears parse state and both valids; speed_limit goes to 255.
module serial_differential_drive_command_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [7:0]  csr_wdata,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata    // [1:0] left_direction, [9:2] left_speed,
                                         // [11:10] right_direction, [19:12] right_speed
);
   import sddc_pkg::*;

   logic [ByteWidth-1:0] limit_q_ff, limit_in;
   logic                 in_valid_ff, in_valid_in;
   logic [ByteWidth-1:0] in_byte_ff, in_byte_in;
   logic                 nonempty_ff, nonempty_in;
   logic                 lead_space_ff, lead_space_in;
   logic                 second_ff, second_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [23:0]          rsp_data_ff, rsp_data_in;

   logic          eol;
   logic          advance;
   logic          good_line;
   field_ctl_type first_ctl, second_ctl;
   number_type    first_num, second_num;
   logic signed [ValueWidth-1:0] x_val, y_val, left_cmd, right_cmd;
   dir_type              left_dir, right_dir;
   logic [ByteWidth-1:0] left_spd, right_spd;

   assign eol     = (in_byte_ff == CharLf) || (in_byte_ff == CharCr);
   assign advance = in_valid_ff && (!eol || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign good_line = nonempty_ff && second_ff && !lead_space_ff;

   assign first_ctl.clear  = advance && eol;
   assign first_ctl.step   = advance && !eol && !second_ff && (in_byte_ff != CharSpace);
   assign second_ctl.clear = advance && eol;
   assign second_ctl.step  = advance && !eol && second_ff;

   sddc_field u_first (
      .clock   (clock),
      .reset   (reset),
      .ctl     (first_ctl),
      .rx_byte (in_byte_ff),
      .number  (first_num)
   );

   sddc_field u_second (
      .clock   (clock),
      .reset   (reset),
      .ctl     (second_ctl),
      .rx_byte (in_byte_ff),
      .number  (second_num)
   );

   assign x_val = first_num.negative ?
                  -$signed({2'b0, first_num.magnitude}) : $signed({2'b0, first_num.magnitude});
   assign y_val = second_num.negative ?
                  -$signed({2'b0, second_num.magnitude}) : $signed({2'b0, second_num.magnitude});
   assign left_cmd  = y_val + x_val;
   assign right_cmd = y_val - x_val;

   sddc_motor u_left (
      .command   (left_cmd),
      .limit     (limit_q_ff),
      .direction (left_dir),
      .speed     (left_spd)
   );

   sddc_motor u_right (
      .command   (right_cmd),
      .limit     (limit_q_ff),
      .direction (right_dir),
      .speed     (right_spd)
   );

   always_comb begin
      limit_in = limit_q_ff;
      if (csr_we) begin
         limit_in = csr_wdata;
      end

      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_tdata;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      nonempty_in   = nonempty_ff;
      lead_space_in = lead_space_ff;
      second_in     = second_ff;
      if (advance) begin
         if (eol) begin
            nonempty_in   = 1'b0;
            lead_space_in = 1'b0;
            second_in     = 1'b0;
         end else begin
            if (!nonempty_ff) begin
               nonempty_in   = 1'b1;
               lead_space_in = (in_byte_ff == CharSpace);
            end
            if (!second_ff && (in_byte_ff == CharSpace)) begin
               second_in = 1'b1;
            end
         end
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (advance && eol && good_line) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {4'b0, right_spd, right_dir, left_spd, left_dir};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_q_ff    <= LimitReset;
         in_valid_ff   <= 1'b0;
         nonempty_ff   <= 1'b0;
         lead_space_ff <= 1'b0;
         second_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         limit_q_ff    <= limit_in;
         in_valid_ff   <= in_valid_in;
         nonempty_ff   <= nonempty_in;
         lead_space_ff <= lead_space_in;
         second_ff     <= second_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff  <= in_byte_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import sddc_pkg::*;

   typedef struct {
      dir_type        left_dir;
      logic [7:0]     left_spd;
      dir_type        right_dir;
      logic [7:0]     right_spd;
   } drive_cmd_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [7:0]  csr_wdata = 8'd0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;     // [7:0] rx_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;            // [1:0] left_direction, [9:2] left_speed,
                                      // [11:10] right_direction, [19:12] right_speed

   serial_differential_drive_command_unit dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #2 clock = ~clock;

   logic [7:0]          rx_pending[$];
   drive_cmd_type       expected_cmds[$];
   int                  phase_bytes = 0;
   int                  bytes_sent = 0;
   int                  cmds_checked = 0;
   int                  mismatches = 0;
   bit                  calm = 1'b0;
   bit                  byte_taken = 1'b0;
   int                  req_gap = 0;
   int                  rsp_gap = 0;

   // line parser state, one slot per number field
   logic [7:0]          speed_limit = LimitReset;
   bit                  line_nonempty = 1'b0;
   bit                  lead_space = 1'b0;
   bit                  in_second = 1'b0;
   phase_type           field_phase[2] = '{PH_SKIP, PH_SKIP};
   bit                  field_neg[2] = '{1'b0, 1'b0};
   logic [MagWidth-1:0] field_mag[2] = '{'0, '0};

   function automatic bit is_blank(input logic [7:0] b);
      return b == CharTab || b == CharVt || b == CharFf || b == CharSpace;
   endfunction

   function automatic longint field_value(input int f);
      longint m;
      m = longint'(field_mag[f]);
      return field_neg[f] ? -m : m;
   endfunction

   function automatic void motor_cmd(input longint v, output dir_type d,
                                     output logic [7:0] s);
      longint lim;
      longint a;
      lim = longint'(speed_limit);
      if (v > lim) v = lim;
      if (v < -lim) v = -lim;
      a = (v < 0) ? -v : v;
      s = a[7:0];
      if (v > 0) d = DIR_FORWARD;
      else if (v < 0) d = DIR_BACKWARD;
      else d = DIR_RELEASE;
   endfunction

   task automatic parse_byte(input logic [7:0] b);
      drive_cmd_type cmd;
      longint     x;
      longint     y;
      longint     acc;
      int         f;
      bit         digit;
      if (b == CharLf || b == CharCr) begin
         if (line_nonempty && in_second && !lead_space) begin
            x = field_value(0);
            y = field_value(1);
            motor_cmd(y + x, cmd.left_dir, cmd.left_spd);
            motor_cmd(y - x, cmd.right_dir, cmd.right_spd);
            expected_cmds.push_back(cmd);
         end
         line_nonempty = 1'b0;
         lead_space = 1'b0;
         in_second = 1'b0;
         for (int i = 0; i < 2; i++) begin
            field_phase[i] = PH_SKIP;
            field_neg[i] = 1'b0;
            field_mag[i] = '0;
         end
         return;
      end
      if (!line_nonempty) begin
         line_nonempty = 1'b1;
         lead_space = (b == CharSpace);
      end
      if (!in_second && b == CharSpace) begin
         in_second = 1'b1;
         return;
      end
      f = in_second;
      digit = (b >= CharZero && b <= CharNine);
      if (field_phase[f] == PH_SKIP) begin
         if (is_blank(b)) begin
            return;
         end else if (b == CharPlus || b == CharMinus) begin
            field_neg[f] = (b == CharMinus);
            field_phase[f] = PH_DIGITS;
         end else if (digit) begin
            field_mag[f] = MagWidth'(b - CharZero);
            field_phase[f] = PH_DIGITS;
         end else begin
            field_phase[f] = PH_STOP;
         end
      end else if (field_phase[f] == PH_DIGITS) begin
         if (digit) begin
            acc = longint'(field_mag[f]) * 10 + longint'(b - CharZero);
            field_mag[f] = (acc > longint'(MagMax)) ? MagMax : acc[MagWidth-1:0];
         end else begin
            field_phase[f] = PH_STOP;
         end
      end
   endtask

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   // monitor and predictor
   always @(posedge clock) begin : monitor
      drive_cmd_type want;
      byte_taken = req_tvalid && req_tready;
      if (!reset) begin
         if (csr_we) speed_limit = csr_wdata;
         if (byte_taken) begin
            parse_byte(req_tdata);
            void'(rx_pending.pop_front());
            bytes_sent++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_cmds.size() == 0) begin
               $error("drive command %h with none expected", rsp_tdata);
               mismatches++;
            end else begin
               want = expected_cmds.pop_front();
               check_field("left_direction", want.left_dir, rsp_tdata[1:0]);
               check_field("left_speed", want.left_spd, rsp_tdata[9:2]);
               check_field("right_direction", want.right_dir, rsp_tdata[11:10]);
               check_field("right_speed", want.right_spd, rsp_tdata[19:12]);
               cmds_checked++;
            end
         end
      end
   end

   // byte driver
   always @(negedge clock) begin
      if (req_tvalid && !byte_taken) begin
         // hold the beat until taken
      end else if (req_gap > 0) begin
         req_gap--;
         req_tvalid <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
         req_gap = $urandom_range(0, 3);
         req_tvalid <= 1'b0;
      end else if (rx_pending.size() > 0) begin
         req_tvalid <= 1'b1;
         req_tdata <= rx_pending[0];
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // result backpressure
   always @(negedge clock) begin
      if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
         rsp_gap = $urandom_range(0, 3);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic push_byte(input logic [7:0] b);
      rx_pending.push_back(b);
      phase_bytes++;
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) push_byte(s[i]);
   endtask

   task automatic push_blank(input bit allow_space);
      case ($urandom_range(0, allow_space ? 3 : 2))
         0: push_byte(CharTab);
         1: push_byte(CharVt);
         2: push_byte(CharFf);
         default: push_byte(CharSpace);
      endcase
   endtask

   task automatic push_number();
      int n;
      case ($urandom_range(0, 3))
         0: push_byte(CharMinus);
         1: push_byte(CharPlus);
         default: ;
      endcase
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 14) : $urandom_range(0, 3);
      if (n == 0 && $urandom_range(0, 1)) n = 1;
      repeat (n) push_byte(CharZero + 8'($urandom_range(0, 9)));
      if ($urandom_range(0, 7) == 0) push_byte(8'($urandom_range(97, 122)));
   endtask

   task automatic push_line_end();
      push_byte($urandom_range(0, 1) ? CharLf : CharCr);
   endtask

   task automatic random_line();
      int kind;
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
         if ($urandom_range(0, 5) == 0) push_blank(1'b0);
         push_number();
         push_byte(CharSpace);
         if ($urandom_range(0, 4) == 0) push_blank(1'b1);
         push_number();
      end else if (kind == 7) begin
         repeat ($urandom_range(1, 10)) push_byte(8'($urandom_range(0, 255)));
      end else if (kind == 8) begin
         push_byte(CharSpace);
         push_number();
         push_byte(CharSpace);
         push_number();
      end else if (kind == 9 && $urandom_range(0, 1)) begin
         push_number();
      end
      push_line_end();
   endtask

   task automatic write_limit(input logic [7:0] v);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_idle();
      while (rx_pending.size() != 0 || expected_cmds.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      int limits[6];
      limits = '{255, 0, 1, 0, 128, 255};
      limits[3] = $urandom_range(2, 254);
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (int p = 0; p < 6; p++) begin
         calm = (p == 5);
         write_limit(limits[p]);
         phase_bytes = 0;
         if (p == 0) begin
            push_text("0 0\n");
            push_text("255 255\n");
            push_text("-255 -255");
            push_byte(CharCr);
            push_byte(CharLf);
            push_text("12\n");
            push_text(" 3 4\n");
            push_text("+7 -9\n");
            push_text("x 5 9\n");
            push_text("4");
            push_byte(8'h00);
            push_text("1 ");
            push_byte(8'hFF);
            push_text("2\n");
            push_byte(CharTab);
            push_byte(CharVt);
            push_text("6 ");
            push_byte(CharFf);
            push_byte(CharTab);
            push_text("-2");
            push_byte(CharCr);
            push_text("99999999999 -99999999999\n");
            push_text("- +\n");
         end else if (p == 1) begin
            push_text("100 -50\n-3 3\n");
         end
         while (phase_bytes < 210) random_line();
         push_byte(CharLf);
         wait_idle();
      end
      repeat (8) @(posedge clock);
      if (expected_cmds.size() != 0) begin
         $error("%0d drive commands never arrived", expected_cmds.size());
         mismatches += expected_cmds.size();
      end
      $display("run covered %0d bytes and %0d drive commands over 6 speed limits",
               bytes_sent, cmds_checked);
      if (mismatches == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("testbench: FAIL");
      $finish;
   end

endmodule
`default_nettype wire
